// ===== sv/mas_pkg.sv =====
// ----------------------------------------------------------------------------
// mas_pkg
// Shared widths and register indexes for the modular add / scalar multiply unit.
// ----------------------------------------------------------------------------
package mas_pkg;

  localparam int unsigned PORT_W    = 64;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALAR  = 1'b1;

  localparam logic ACT_ADD = 1'b0;
  localparam logic ACT_MUL = 1'b1;

  typedef struct packed {
    logic vld;
    logic act;
  } mas_ctl_t;

endpackage

// ===== sv/mas_front.sv =====
// ----------------------------------------------------------------------------
// mas_front
// Two-stage front end: partial products and raw sum, then full product and
// conditional modulus subtraction for add beats.
// ----------------------------------------------------------------------------
module mas_front import mas_pkg::*; #(
  parameter int unsigned W = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  mas_ctl_t         ctl_i,
  input  logic [W-1:0]     a_i,
  input  logic [W-1:0]     b_i,
  input  logic [W-1:0]     scalar_i,
  input  logic [W-1:0]     q_i,
  output mas_ctl_t         ctl_o,
  output logic [2*W-1:0]   prod_o,
  output logic [W-1:0]     sum_o
);

  localparam int unsigned LO = W / 2;
  localparam int unsigned HI = W - LO;
  localparam int unsigned PW = 2 * W;

  mas_ctl_t          ctl1_r;
  logic [2*LO-1:0]   pp0_r;
  logic [LO+HI-1:0]  pp1_r;
  logic [LO+HI-1:0]  pp2_r;
  logic [2*HI-1:0]   pp3_r;
  logic [W-1:0]      sum1_r;
  logic              cy1_r;

  mas_ctl_t          ctl2_r;
  logic [PW-1:0]     prod2_r;
  logic [W-1:0]      sum2_r;

  logic [PW-1:0]     prod_nxt;
  logic [W-1:0]      sum_nxt;
  logic [W:0]        raw_sum;

  assign raw_sum = {1'b0, a_i} + {1'b0, b_i};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r <= '0;
    end else if (en) begin
      ctl1_r <= ctl_i;
    end
    if (en) begin
      pp0_r  <= a_i[LO-1:0] * scalar_i[LO-1:0];
      pp1_r  <= a_i[LO-1:0] * scalar_i[W-1:LO];
      pp2_r  <= a_i[W-1:LO] * scalar_i[LO-1:0];
      pp3_r  <= a_i[W-1:LO] * scalar_i[W-1:LO];
      sum1_r <= raw_sum[W-1:0];
      cy1_r  <= raw_sum[W];
    end
  end

  always_comb begin
    prod_nxt = PW'(pp0_r) + (PW'(pp1_r) << LO) + (PW'(pp2_r) << LO)
             + (PW'(pp3_r) << (2 * LO));
    if (cy1_r || (sum1_r >= q_i)) begin
      sum_nxt = sum1_r - q_i;
    end else begin
      sum_nxt = sum1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
    end else if (en) begin
      ctl2_r <= ctl1_r;
    end
    if (en) begin
      prod2_r <= prod_nxt;
      sum2_r  <= sum_nxt;
    end
  end

  assign ctl_o  = ctl2_r;
  assign prod_o = prod2_r;
  assign sum_o  = sum2_r;

endmodule

// ===== sv/mas_rstep.sv =====
// ----------------------------------------------------------------------------
// mas_rstep
// One restoring reduction step: shift in the next product bit, subtract the
// modulus when the partial remainder reaches it.
// ----------------------------------------------------------------------------
module mas_rstep import mas_pkg::*; #(
  parameter int unsigned W = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [W-1:0]     q_i,
  input  mas_ctl_t         ctl_i,
  input  logic [W-1:0]     rem_i,
  input  logic [2*W-1:0]   prod_i,
  input  logic [W-1:0]     sum_i,
  output mas_ctl_t         ctl_o,
  output logic [W-1:0]     rem_o,
  output logic [2*W-1:0]   prod_o,
  output logic [W-1:0]     sum_o
);

  mas_ctl_t        ctl_r;
  logic [W-1:0]    rem_r;
  logic [2*W-1:0]  prod_r;
  logic [W-1:0]    sum_r;

  logic [W:0]      shifted;
  logic [W-1:0]    rem_nxt;

  always_comb begin
    shifted = {rem_i, prod_i[2*W-1]};
    // carry bit set means the shifted value already exceeds any modulus
    if (shifted >= {1'b0, q_i}) begin
      rem_nxt = shifted[W-1:0] - q_i;
    end else begin
      rem_nxt = shifted[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (en) begin
      ctl_r <= ctl_i;
    end
    if (en) begin
      rem_r  <= rem_nxt;
      prod_r <= {prod_i[2*W-2:0], 1'b0};
      sum_r  <= sum_i;
    end
  end

  assign ctl_o  = ctl_r;
  assign rem_o  = rem_r;
  assign prod_o = prod_r;
  assign sum_o  = sum_r;

endmodule

// ===== sv/modular_add_scalar_multiply.sv =====
// ----------------------------------------------------------------------------
// modular_add_scalar_multiply
// Streaming modular add / multiply-by-scalar unit for ciphertext elements.
// ----------------------------------------------------------------------------
// Usage:
//   input beats (in_valid/in_ready) carry action, operand_a and operand_b;
//   each beat gives exactly one output beat (out_valid/out_ready) with the
//   reduced element, in order.
//   action 0 returns a+b minus the modulus once if the sum reaches it;
//   action 1 returns a*scalar reduced modulo the modulus, modulus zero
//   meaning 2^WORD_BITS.
//   modulus and scalar are set through cfg_we/cfg_index/cfg_wdata while no
//   beat is in flight.
//   the pipeline has two front stages for the split multiply and the add,
//   one restoring reduction stage per product bit, and the output register.
//   throughput is one beat per cycle. when the receiver stalls the whole
//   pipeline holds and in_ready drops; nothing is lost or repeated.
//   reset (rst_n low, synchronous) empties the pipeline and loads modulus 2
//   and scalar 0.
// ----------------------------------------------------------------------------
module modular_add_scalar_multiply import mas_pkg::*; #(
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_action,
  input  logic [PORT_W-1:0]    in_operand_a,
  input  logic [PORT_W-1:0]    in_operand_b,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PORT_W-1:0]    out_result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PORT_W-1:0]    cfg_wdata
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned NS = 2 * W;

  logic [W-1:0]     modulus_r;
  logic [W-1:0]     scalar_r;
  logic             en;
  mas_ctl_t         in_ctl;

  mas_ctl_t         ctl_a  [0:NS];
  logic [W-1:0]     rem_a  [0:NS];
  logic [2*W-1:0]   prod_a [0:NS];
  logic [W-1:0]     sum_a  [0:NS];

  logic             out_valid_r;
  logic [W-1:0]     out_result_r;
  logic [W-1:0]     result_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= W'(2);
      scalar_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODULUS: modulus_r <= cfg_wdata[W-1:0];
        REG_SCALAR:  scalar_r  <= cfg_wdata[W-1:0];
        default: ;
      endcase
    end
  end

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  assign in_ctl.vld = in_valid && en;
  assign in_ctl.act = in_action;

  mas_front #(.W(W)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .ctl_i    (in_ctl),
    .a_i      (in_operand_a[W-1:0]),
    .b_i      (in_operand_b[W-1:0]),
    .scalar_i (scalar_r),
    .q_i      (modulus_r),
    .ctl_o    (ctl_a[0]),
    .prod_o   (prod_a[0]),
    .sum_o    (sum_a[0])
  );

  assign rem_a[0] = '0;

  for (genvar i = 0; i < NS; i++) begin : g_red
    mas_rstep #(.W(W)) u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .q_i    (modulus_r),
      .ctl_i  (ctl_a[i]),
      .rem_i  (rem_a[i]),
      .prod_i (prod_a[i]),
      .sum_i  (sum_a[i]),
      .ctl_o  (ctl_a[i+1]),
      .rem_o  (rem_a[i+1]),
      .prod_o (prod_a[i+1]),
      .sum_o  (sum_a[i+1])
    );
  end

  assign result_nxt = (ctl_a[NS].act == ACT_MUL) ? rem_a[NS] : sum_a[NS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ctl_a[NS].vld;
    end
    if (en) begin
      out_result_r <= result_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = PORT_W'(out_result_r);

endmodule
